// ===== design/bdtr_pkg.sv =====
`timescale 1ns / 1ps

package bdtr_pkg;

  // rpm = RpmNumerator / (period * poles)
  localparam int unsigned QuoWidth = 27;
  localparam int unsigned DenWidth = 24;
  localparam int unsigned RpmWidth = 26;
  localparam logic [QuoWidth-1:0] RpmNumerator = 27'd120000000;
  localparam logic [RpmWidth-1:0] RpmMax = '1;

  // Stop code: exponent 7, mantissa all ones
  localparam logic [2:0] StopExpo = 3'd7;
  localparam logic [8:0] StopMant = 9'h1FF;

  // Per-request side information carried alongside the division
  typedef struct packed {
    logic        ok;
    logic [15:0] word;
    logic        ext;
    logic        rpm_zero;
  } bdtr_info_t;

  // State of one divider stage
  typedef struct packed {
    bdtr_info_t          info;
    logic [DenWidth-1:0] den;
    logic [DenWidth-1:0] rem;
    logic [QuoWidth-1:0] quo;
  } bdtr_div_t;

  // GCR symbol to nibble; bit 4 set flags a symbol with no code
  function automatic logic [4:0] gcr_nibble(input logic [4:0] sym);
    logic [4:0] res;
    unique case (sym)
      5'd9:    res = 5'h09;
      5'd10:   res = 5'h0A;
      5'd11:   res = 5'h0B;
      5'd13:   res = 5'h0D;
      5'd14:   res = 5'h0E;
      5'd15:   res = 5'h0F;
      5'd18:   res = 5'h02;
      5'd19:   res = 5'h03;
      5'd21:   res = 5'h05;
      5'd22:   res = 5'h06;
      5'd23:   res = 5'h07;
      5'd25:   res = 5'h00;
      5'd26:   res = 5'h08;
      5'd27:   res = 5'h01;
      5'd29:   res = 5'h04;
      5'd30:   res = 5'h0C;
      default: res = 5'h10;
    endcase
    return res;
  endfunction

endpackage

// ===== design/bdtr_decode.sv =====
`timescale 1ns / 1ps

module bdtr_decode import bdtr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [20:0] wire_bits_i,
  input  logic [7:0]  pole_i,
  input  logic        ready_i,
  output logic        valid_o,
  output bdtr_info_t  info_o,
  output logic [15:0] period_o,
  output logic [7:0]  pole_o
);

  logic        valid_q;
  bdtr_info_t  info_d, info_q;
  logic [15:0] period_d, period_q;
  logic [7:0]  pole_q;

  logic [19:0] gcr;
  logic [4:0]  nib [4];
  logic [15:0] word;
  logic        ok;
  logic [2:0]  expo;
  logic [8:0]  mant;

  // Undo transition coding, then map the four symbols
  always_comb begin
    gcr = wire_bits_i[19:0] ^ wire_bits_i[20:1];
    for (int k = 0; k < 4; k++) begin
      nib[k] = gcr_nibble(gcr[5*k +: 5]);
    end
    ok   = !(nib[0][4] | nib[1][4] | nib[2][4] | nib[3][4]);
    word = ok ? {nib[3][3:0], nib[2][3:0], nib[1][3:0], nib[0][3:0]} : 16'h0000;
    expo = word[15:13];
    mant = word[12:4];

    info_d.ok       = ok;
    info_d.word     = word;
    info_d.ext      = (word[15:12] != 4'h0) && !word[12];
    info_d.rpm_zero = !ok || (mant == 9'h000) || ((expo == StopExpo) && (mant == StopMant)) ||
                      (pole_i == 8'h00);
    period_d        = {7'h00, mant} << expo;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      info_q   <= info_d;
      period_q <= period_d;
      pole_q   <= pole_i;
    end
  end

  assign valid_o  = valid_q;
  assign info_o   = info_q;
  assign period_o = period_q;
  assign pole_o   = pole_q;

endmodule

// ===== design/bdtr_denom.sv =====
`timescale 1ns / 1ps

module bdtr_denom import bdtr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  bdtr_info_t  info_i,
  input  logic [15:0] period_i,
  input  logic [7:0]  pole_i,
  input  logic        ready_i,
  output logic        valid_o,
  output bdtr_div_t   div_o
);

  logic      valid_q;
  bdtr_div_t div_d, div_q;

  // Denominator = period * poles; divider starts with empty remainder
  always_comb begin
    div_d.info = info_i;
    div_d.den  = DenWidth'(period_i) * DenWidth'(pole_i);
    div_d.rem  = '0;
    div_d.quo  = '0;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

// ===== design/bdtr_div_stage.sv =====
`timescale 1ns / 1ps

module bdtr_div_stage import bdtr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  logic      num_bit_i,
  input  bdtr_div_t div_i,
  input  logic      ready_i,
  output logic      valid_o,
  output bdtr_div_t div_o
);

  logic            valid_q;
  bdtr_div_t       div_d, div_q;
  logic [DenWidth:0] trial;
  logic [DenWidth:0] diff;
  logic            take;

  // One restoring step: bring in a numerator bit, subtract if it fits
  always_comb begin
    trial = {div_i.rem, num_bit_i};
    diff  = trial - {1'b0, div_i.den};
    take  = trial >= {1'b0, div_i.den};

    div_d.info = div_i.info;
    div_d.den  = div_i.den;
    div_d.rem  = take ? diff[DenWidth-1:0] : trial[DenWidth-1:0];
    div_d.quo  = {div_i.quo[QuoWidth-2:0], take};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

// ===== design/bdshot_telemetry_rpm_decoder_unit.sv =====
`timescale 1ns / 1ps

// Channel    Direction  Handshake                Payload
// input      in         in_valid_i / in_stall_o  wire_bits_i
// output     out        out_valid_o / out_stall_i valid_res_o, telemetry_word_o,
//                                                 is_extended_o, rpm_o
// config     in         APB write/read           pole_count at byte address 0
//
// One request per cycle while out_stall_i is low; the stages are GCR decode, denominator multiply,
// 27 restoring divider stages (one quotient bit each), output register.
// Reset clears all stage valid bits and sets pole_count to 14.
// Each stage holds while the stage after it is full and stalled, so bubbles
// collapse and in_stall_o rises only when every stage is occupied.

module bdshot_telemetry_rpm_decoder_unit import bdtr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [20:0]         wire_bits_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                valid_res_o,
  output logic [15:0]         telemetry_word_o,
  output logic                is_extended_o,
  output logic [RpmWidth-1:0] rpm_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned NumStages = QuoWidth;

  // Configuration register
  logic [7:0] pole_count_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'h000000, pole_count_q} : 32'h00000000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_count_q <= 8'd14;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      pole_count_q <= pwdata[7:0];
    end
  end

  // Decode stage
  logic        dec_ready, dec_valid;
  bdtr_info_t  dec_info;
  logic [15:0] dec_period;
  logic [7:0]  dec_pole;
  logic        den_ready, den_valid;
  bdtr_div_t   den_div;

  logic      stg_valid [NumStages+1];
  logic      stg_ready [NumStages+1];
  bdtr_div_t stg_div   [NumStages+1];

  logic out_ready;

  assign in_stall_o = !dec_ready;

  bdtr_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .ready_o     (dec_ready),
    .wire_bits_i (wire_bits_i),
    .pole_i      (pole_count_q),
    .ready_i     (den_ready),
    .valid_o     (dec_valid),
    .info_o      (dec_info),
    .period_o    (dec_period),
    .pole_o      (dec_pole)
  );

  // Denominator stage
  bdtr_denom u_denom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (dec_valid),
    .ready_o  (den_ready),
    .info_i   (dec_info),
    .period_i (dec_period),
    .pole_i   (dec_pole),
    .ready_i  (stg_ready[0]),
    .valid_o  (den_valid),
    .div_o    (den_div)
  );

  assign stg_valid[0] = den_valid;
  assign stg_div[0]   = den_div;

  // Divider pipeline, numerator bits most significant first
  for (genvar k = 0; k < NumStages; k++) begin : g_div
    bdtr_div_stage u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (stg_valid[k]),
      .ready_o   (stg_ready[k]),
      .num_bit_i (RpmNumerator[NumStages-1-k]),
      .div_i     (stg_div[k]),
      .ready_i   (stg_ready[k+1]),
      .valid_o   (stg_valid[k+1]),
      .div_o     (stg_div[k+1])
    );
  end

  assign stg_ready[NumStages] = out_ready;

  // Output register with saturation
  logic                out_valid_q;
  logic                valid_res_q;
  logic [15:0]         word_q;
  logic                ext_q;
  logic [RpmWidth-1:0] rpm_d, rpm_q;
  bdtr_div_t           fin;

  assign fin       = stg_div[NumStages];
  assign out_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    if (fin.info.rpm_zero) begin
      rpm_d = '0;
    end else if (fin.quo[QuoWidth-1]) begin
      rpm_d = RpmMax;
    end else begin
      rpm_d = fin.quo[RpmWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= stg_valid[NumStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && stg_valid[NumStages]) begin
      valid_res_q <= fin.info.ok;
      word_q      <= fin.info.word;
      ext_q       <= fin.info.ext;
      rpm_q       <= rpm_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign valid_res_o      = valid_res_q;
  assign telemetry_word_o = word_q;
  assign is_extended_o    = ext_q;
  assign rpm_o            = rpm_q;

endmodule
